FILE: rtl/bitstream_field_reader_defines.svh
// Assertion macros for the bitstream field reader.
// No dependencies.
`ifndef BITSTREAM_FIELD_READER_DEFINES_SVH
`define BITSTREAM_FIELD_READER_DEFINES_SVH
`ifndef SYNTH
`define BFR_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define BFR_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define BFR_ASSERT_IMP(label, clk, rst, a, c)
`define BFR_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

FILE: rtl/bfr_pkg.sv
// Shared types and constants for the bitstream field reader.
// No dependencies.
package bfr_pkg;
   localparam int BufBytes     = 4096;
   localparam int SaveSlots    = 8;
   localparam int MaxFieldBits = 64;

   localparam logic [2:0] FUNC_WRITE   = 3'd0;
   localparam logic [2:0] FUNC_START   = 3'd1;
   localparam logic [2:0] FUNC_GET     = 3'd2;
   localparam logic [2:0] FUNC_SKIP    = 3'd3;
   localparam logic [2:0] FUNC_TAIL    = 3'd4;
   localparam logic [2:0] FUNC_SAVE    = 3'd5;
   localparam logic [2:0] FUNC_RESTORE = 3'd6;

   typedef enum logic [2:0] {
      ST_IDLE, ST_EXEC, ST_READ, ST_FINISH, ST_DONE
   } state_type;

   typedef struct packed {
      logic load;      // capture request
      logic exec;      // simple operation / get check
      logic rd_issue;  // issue byte read
      logic rd_take;   // shift in byte read last cycle
      logic finish;    // align and commit get
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic is_get;    // captured request is a successful nonzero get
      logic rd_last;   // issuing last byte read
   } status_type;
endpackage

FILE: rtl/bfr_ctrl.sv
// Controller state machine for the bitstream field reader.
// Depends on bfr_pkg.
module bfr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bfr_pkg::status_type status,
   output bfr_pkg::cmd_type    cmd
);
   bfr_pkg::state_type state_ff, state_in;
   logic               take_ff, take_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfr_pkg::ST_IDLE;
         take_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         take_ff  <= take_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfr_pkg::ST_IDLE:   if (start) state_in = bfr_pkg::ST_EXEC;
         bfr_pkg::ST_EXEC:   state_in = status.is_get ? bfr_pkg::ST_READ : bfr_pkg::ST_DONE;
         bfr_pkg::ST_READ:   if (status.rd_last) state_in = bfr_pkg::ST_FINISH;
         bfr_pkg::ST_FINISH: state_in = bfr_pkg::ST_DONE;
         bfr_pkg::ST_DONE:   state_in = bfr_pkg::ST_IDLE;
         default:            state_in = bfr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      take_in = 1'b0;
      busy = (state_ff != bfr_pkg::ST_IDLE);
      case (state_ff)
         bfr_pkg::ST_IDLE: cmd.load = start;
         bfr_pkg::ST_EXEC: cmd.exec = 1'b1;
         bfr_pkg::ST_READ: begin
            cmd.rd_issue = 1'b1;
            cmd.rd_take  = take_ff;
            take_in      = 1'b1;
         end
         bfr_pkg::ST_FINISH: begin
            cmd.rd_take = 1'b1;
         end
         bfr_pkg::ST_DONE: begin
            cmd.finish  = 1'b1;
            cmd.respond = 1'b1;
         end
         default: ;
      endcase
   end
endmodule

FILE: rtl/bfr_datapath.sv
// Datapath: byte buffer, position registers, save slots, field assembly.
// Depends on bfr_pkg.
module bfr_datapath #(
   parameter int BUF_BYTES      = bfr_pkg::BufBytes,
   parameter int SAVE_SLOTS     = bfr_pkg::SaveSlots,
   parameter int MAX_FIELD_BITS = bfr_pkg::MaxFieldBits
) (
   input  logic                clock,
   input  logic                reset,
   input  bfr_pkg::cmd_type    cmd,
   output bfr_pkg::status_type status,
   input  logic [2:0]          req_func,
   input  logic [15:0]         req_num_bits,
   input  logic                req_little_endian,
   input  logic                req_is_signed,
   input  logic [2:0]          req_slot,
   input  logic [11:0]         req_byte_addr,
   input  logic [7:0]          req_byte_data,
   output logic                rsp_ok,
   output logic [63:0]         rsp_value,
   output logic [15:0]         rsp_offset_now
);
   localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam int SW = (SAVE_SLOTS > 1) ? $clog2(SAVE_SLOTS) : 1;

   logic [7:0]  mem [BUF_BYTES];
   logic [31:0] slots_ff [SAVE_SLOTS];
   logic [SAVE_SLOTS-1:0] slot_vld_ff;

   logic [2:0]  func_ff;
   logic [15:0] nb_ff;
   logic        le_ff, sgn_ff;
   logic [2:0]  slot_ff;
   logic [11:0] addr_ff;
   logic [7:0]  data_ff;
   logic [15:0] size_ff, size_in, off_ff, off_in;
   logic        ok_ff, ok_in, get_ff;
   logic [63:0] val_ff;
   logic [71:0] acc_ff;
   logic [3:0]  nbytes_ff, rcnt_ff;
   logic [15:0] rdbyte_ff;
   logic [7:0]  rdata_ff;

   logic [15:0] remain;
   logic [16:0] skip_sum;
   logic        slot_ok;
   logic [SW-1:0] sidx;
   logic [31:0] slot_rd;

   assign remain   = (size_ff > off_ff) ? size_ff - off_ff : 16'd0;
   assign skip_sum = {1'b0, off_ff} + {1'b0, nb_ff};
   assign slot_ok  = ({13'd0, slot_ff} < 16'(SAVE_SLOTS));
   assign sidx     = SW'(slot_ff);
   assign slot_rd  = slot_vld_ff[sidx] ? slots_ff[sidx] : 32'd0;

   // bytes spanned by the field
   logic [15:0] span_end;
   assign span_end = 16'({13'd0, off_ff[2:0]} + nb_ff + 16'd7);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         nb_ff   <= req_num_bits;
         le_ff   <= req_little_endian;
         sgn_ff  <= req_is_signed;
         slot_ff <= req_slot;
         addr_ff <= req_byte_addr;
         data_ff <= req_byte_data;
      end
   end

   always_comb begin
      size_in = size_ff;
      off_in  = off_ff;
      ok_in   = ok_ff;
      if (cmd.exec) begin
         ok_in = 1'b0;
         case (func_ff)
            bfr_pkg::FUNC_WRITE: ok_in = 1'b1;
            bfr_pkg::FUNC_START: begin
               size_in = nb_ff; off_in = '0; ok_in = 1'b1;
            end
            bfr_pkg::FUNC_GET:
               ok_in = (nb_ff == 16'd0) ||
                       (remain >= nb_ff && nb_ff <= 16'(MAX_FIELD_BITS));
            bfr_pkg::FUNC_SKIP:
               if (skip_sum <= {1'b0, size_ff}) begin
                  off_in = skip_sum[15:0]; ok_in = 1'b1;
               end
            bfr_pkg::FUNC_TAIL: ok_in = (remain == nb_ff);
            bfr_pkg::FUNC_SAVE: ok_in = slot_ok;
            bfr_pkg::FUNC_RESTORE:
               if (slot_ok) begin
                  size_in = slot_rd[31:16]; off_in = slot_rd[15:0]; ok_in = 1'b1;
               end
            default: ;
         endcase
      end
      if (cmd.finish && get_ff) off_in = off_ff + nb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= '0;
         off_ff      <= '0;
         ok_ff       <= 1'b0;
         get_ff      <= 1'b0;
         slot_vld_ff <= '0;
      end else begin
         size_ff <= size_in;
         off_ff  <= off_in;
         ok_ff   <= ok_in;
         if (cmd.exec) begin
            get_ff <= (func_ff == bfr_pkg::FUNC_GET) && ok_in && (nb_ff != 16'd0);
            if (func_ff == bfr_pkg::FUNC_SAVE && slot_ok)
               slot_vld_ff[sidx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && func_ff == bfr_pkg::FUNC_SAVE && slot_ok)
         slots_ff[sidx] <= {size_ff, off_ff};
   end

   // buffer memory
   always_ff @(posedge clock) begin
      if (cmd.exec && func_ff == bfr_pkg::FUNC_WRITE)
         mem[AW'(addr_ff)] <= data_ff;
      rdata_ff <= mem[AW'(rdbyte_ff)];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rdbyte_ff <= {3'd0, off_ff[15:3]};
         nbytes_ff <= span_end[6:3];
         rcnt_ff   <= 4'd1;
         acc_ff    <= '0;
      end else if (cmd.rd_issue) begin
         rdbyte_ff <= rdbyte_ff + 16'd1;
         rcnt_ff   <= rcnt_ff + 4'd1;
      end
      if (cmd.rd_take) acc_ff <= {acc_ff[63:0], rdata_ff};
   end

   assign status.is_get  = (func_ff == bfr_pkg::FUNC_GET) &&
                           (nb_ff != 16'd0) && ok_in;
   assign status.rd_last = (rcnt_ff >= nbytes_ff);

   // align: acc holds nbytes bytes, field starts at bit off[2:0] of first
   logic [71:0] left;
   logic [63:0] be_val, le_val, raw, sext;
   logic [6:0]  n7, shl;
   always_comb begin
      n7   = nb_ff[6:0];
      shl  = 7'(7'd72 - {nbytes_ff, 3'd0});
      left = (acc_ff << shl) << off_ff[2:0];
      be_val = left[71:8] >> 7'(7'd64 - n7);
      if (n7 == 7'd64) be_val = left[71:8];
      le_val = '0;
      for (int k = 0; k < 8; k++) begin
         if (7'(8 * k + 8) <= n7)
            le_val[8*k +: 8] = 8'(be_val >> 7'(n7 - 7'(8 * k + 8)));
         else if (7'(8 * k) < n7)
            le_val[8*k +: 8] = 8'(be_val) & 8'((9'd1 << (n7 - 7'(8 * k))) - 9'd1);
      end
      raw  = le_ff ? le_val : be_val;
      sext = raw;
      if (sgn_ff && n7 < 7'd64 && raw[6'(n7 - 7'd1)])
         sext = raw | (~64'd0 << n7);
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) val_ff <= '0;
      else if (cmd.finish && get_ff) val_ff <= sext;
   end

   assign rsp_ok         = ok_ff;
   assign rsp_value      = (cmd.finish && get_ff) ? sext : val_ff;
   assign rsp_offset_now = off_in;
endmodule

FILE: rtl/bitstream_field_reader.sv
// Bitstream field reader: one item per command, one result per item.
// The result strobe follows acceptance through states EXEC and DONE; a nonzero get
// that succeeds and spans B buffer bytes (B up to 9, one byte read a cycle) also
// passes READ and FINISH. A new item is accepted only in IDLE, after the last result; no stalls.
// Synchronous reset clears size, offset and save slots; buffer is undefined.
module bitstream_field_reader #(
   parameter int BUF_BYTES      = bfr_pkg::BufBytes,
   parameter int SAVE_SLOTS     = bfr_pkg::SaveSlots,
   parameter int MAX_FIELD_BITS = bfr_pkg::MaxFieldBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_num_bits,
   input  logic        req_little_endian,
   input  logic        req_is_signed,
   input  logic [2:0]  req_slot,
   input  logic [11:0] req_byte_addr,
   input  logic [7:0]  req_byte_data,
   output logic        rsp_valid,
   output logic        rsp_ok,
   output logic [63:0] rsp_value,
   output logic [15:0] rsp_offset_now
);
`include "bitstream_field_reader_defines.svh"
   bfr_pkg::cmd_type    cmd;
   bfr_pkg::status_type status;

   bfr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .status(status), .cmd(cmd)
   );

   bfr_datapath #(
      .BUF_BYTES(BUF_BYTES), .SAVE_SLOTS(SAVE_SLOTS),
      .MAX_FIELD_BITS(MAX_FIELD_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_func(req_func), .req_num_bits(req_num_bits),
      .req_little_endian(req_little_endian), .req_is_signed(req_is_signed),
      .req_slot(req_slot), .req_byte_addr(req_byte_addr),
      .req_byte_data(req_byte_data), .rsp_ok(rsp_ok), .rsp_value(rsp_value),
      .rsp_offset_now(rsp_offset_now)
   );

   assign rsp_valid = cmd.respond;

   `BFR_ASSERT_NEXT(a_rsp_then_idle, clock, reset, rsp_valid, !busy)
   `BFR_ASSERT_IMP(a_rsp_busy, clock, reset, rsp_valid, busy)
   `BFR_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && !rsp_ok, rsp_value == 64'd0)
endmodule

FILE: bench/bitstream_field_reader_checker.sv
// Checker for the bitstream field reader: watches the command and result ports,
// predicts each result from its own copy of buffer, size, offset and slots.
// Depends on bfr_pkg for the operation codes and buffer sizes.
module bitstream_field_reader_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_num_bits,
   input  logic        req_little_endian,
   input  logic        req_is_signed,
   input  logic [2:0]  req_slot,
   input  logic [11:0] req_byte_addr,
   input  logic [7:0]  req_byte_data,
   input  logic        rsp_valid,
   input  logic        rsp_ok,
   input  logic [63:0] rsp_value,
   input  logic [15:0] rsp_offset_now,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic        ok;
      logic [63:0] value;
      logic [15:0] offset_now;
   } field_result_type;

   logic [7:0]  buf_bytes [bfr_pkg::BufBytes];
   logic [15:0] match_size;
   logic [15:0] read_pos;
   logic [31:0] saved_pos [bfr_pkg::SaveSlots];
   field_result_type expected_results[$];

   function automatic logic stream_bit(int unsigned pos);
      logic [7:0] b;
      b = buf_bytes[(pos >> 3) % bfr_pkg::BufBytes];
      return b[7 - (pos & 7)];
   endfunction

   function automatic field_result_type read_field(logic [15:0] n, logic le, logic sgn);
      field_result_type r;
      logic [63:0] v;
      int unsigned left;
      int unsigned chunk;
      logic [63:0] part;
      r.ok = 1'b0;
      r.value = '0;
      v = '0;
      left = (match_size > read_pos) ? match_size - read_pos : 0;
      if (n == 0) begin
         r.ok = 1'b1;
      end else if (left >= n && n <= bfr_pkg::MaxFieldBits) begin
         if (le) begin
            for (int k = 0; 8 * k < n; k++) begin
               chunk = (n - 8 * k >= 8) ? 8 : n - 8 * k;
               part = '0;
               for (int i = 0; i < chunk; i++)
                  part = (part << 1) | stream_bit(read_pos + 8 * k + i);
               v |= part << (8 * k);
            end
         end else begin
            for (int i = 0; i < n; i++)
               v = (v << 1) | stream_bit(read_pos + i);
         end
         if (sgn && n < 64 && v[n - 1])
            v |= ~64'd0 << n;
         read_pos = read_pos + n;
         r.ok = 1'b1;
         r.value = v;
      end
      return r;
   endfunction

   function automatic field_result_type predict_field_result();
      field_result_type r;
      logic [16:0] new_off;
      r.ok = 1'b0;
      r.value = '0;
      case (req_func)
         bfr_pkg::FUNC_WRITE: begin
            buf_bytes[req_byte_addr % bfr_pkg::BufBytes] = req_byte_data;
            r.ok = 1'b1;
         end
         bfr_pkg::FUNC_START: begin
            match_size = req_num_bits;
            read_pos = '0;
            r.ok = 1'b1;
         end
         bfr_pkg::FUNC_GET: r = read_field(req_num_bits, req_little_endian, req_is_signed);
         bfr_pkg::FUNC_SKIP: begin
            new_off = read_pos + req_num_bits;
            if (new_off <= match_size) begin
               read_pos = new_off[15:0];
               r.ok = 1'b1;
            end
         end
         bfr_pkg::FUNC_TAIL: begin
            r.ok = (((match_size > read_pos) ? match_size - read_pos : 16'd0)
                    == req_num_bits);
         end
         bfr_pkg::FUNC_SAVE: begin
            if (req_slot < bfr_pkg::SaveSlots) begin
               saved_pos[req_slot] = {match_size, read_pos};
               r.ok = 1'b1;
            end
         end
         bfr_pkg::FUNC_RESTORE: begin
            if (req_slot < bfr_pkg::SaveSlots) begin
               {match_size, read_pos} = saved_pos[req_slot];
               r.ok = 1'b1;
            end
         end
         default: ;
      endcase
      r.offset_now = read_pos;
      return r;
   endfunction

   assign pending = expected_results.size();

   initial begin
      fail_count = 0;
      match_size = '0;
      read_pos = '0;
      for (int i = 0; i < bfr_pkg::SaveSlots; i++) saved_pos[i] = '0;
      for (int i = 0; i < bfr_pkg::BufBytes; i++) buf_bytes[i] = '0;
   end

   always @(posedge clock) begin
      field_result_type e;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: ok=%0b value=%h offset=%0d",
                           rsp_ok, rsp_value, rsp_offset_now);
            end else begin
               e = expected_results.pop_front();
               if (rsp_ok !== e.ok || rsp_value !== e.value
                   || rsp_offset_now !== e.offset_now) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp ok=%0b v=%h off=%0d got ok=%0b v=%h off=%0d",
                              e.ok, e.value, e.offset_now,
                              rsp_ok, rsp_value, rsp_offset_now);
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(predict_field_result());
      end
   end
endmodule

FILE: bench/testbench.sv
// Top of the bitstream field reader bench: clock, reset, command stimulus, verdict.
// Depends on bfr_pkg, bitstream_field_reader and bitstream_field_reader_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] FUNC_NOP = 3'd7;
   localparam int RandItems = 850;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_func = '0;
   logic [15:0] req_num_bits = '0;
   logic        req_little_endian = 1'b0;
   logic        req_is_signed = 1'b0;
   logic [2:0]  req_slot = '0;
   logic [11:0] req_byte_addr = '0;
   logic [7:0]  req_byte_data = '0;
   logic        rsp_valid;
   logic        rsp_ok;
   logic [63:0] rsp_value;
   logic [15:0] rsp_offset_now;
   int          fail_count;
   int          pending;

   int items_sent = 0;
   int burst_left = 0;
   int filled = 0;

   always #10 clock = ~clock;

   bitstream_field_reader dut (.*);
   bitstream_field_reader_checker checker_i (.*);

   task automatic send(int unsigned f, int unsigned nb, int unsigned le = 0,
                       int unsigned sg = 0, int unsigned sl = 0, int unsigned ad = 0,
                       int unsigned dt = 0);
      req_func <= 3'(f);
      req_num_bits <= 16'(nb);
      req_little_endian <= 1'(le);
      req_is_signed <= 1'(sg);
      req_slot <= 3'(sl);
      req_byte_addr <= 12'(ad);
      req_byte_data <= 8'(dt);
      start <= 1'b1;
      do @(posedge clock); while (busy);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 10);
      end
   endtask

   function automatic int unsigned field_bits();
      case ($urandom_range(0, 9))
         0: return $urandom_range(65, 300);
         1: return $urandom & 32'hffff;
         default: return $urandom_range(0, 64);
      endcase
   endfunction

   initial begin
      logic [7:0] pat [12] = '{8'h80, 8'hff, 8'h01, 8'h7f, 8'ha5, 8'h5a,
                               8'hc3, 8'h3c, 8'hff, 8'h00, 8'h96, 8'h69};
      int ops;
      int unsigned f;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < 12; i++) send(bfr_pkg::FUNC_WRITE, 0, 0, 0, 0, i, pat[i]);
      filled = 12;
      send(bfr_pkg::FUNC_START, 96);
      send(bfr_pkg::FUNC_GET, 64, 0, 1);
      send(bfr_pkg::FUNC_START, 96);
      send(bfr_pkg::FUNC_SKIP, 3);
      send(bfr_pkg::FUNC_GET, 64, 1, 1);
      send(bfr_pkg::FUNC_GET, 0);
      send(bfr_pkg::FUNC_GET, 65);
      send(bfr_pkg::FUNC_GET, 13, 1, 1);
      send(bfr_pkg::FUNC_TAIL, 16);
      send(bfr_pkg::FUNC_TAIL, 17);
      send(bfr_pkg::FUNC_SAVE, 0, 0, 0, 7);
      send(bfr_pkg::FUNC_SKIP, 200);
      send(bfr_pkg::FUNC_RESTORE, 0, 0, 0, 7);
      send(FUNC_NOP, 16'hffff, 1, 1, 7, 12'hfff, 8'hff);
      send(bfr_pkg::FUNC_WRITE, 0, 0, 0, 0, 12'hfff, 8'hff);
      send(bfr_pkg::FUNC_START, 16'd32768);
      send(bfr_pkg::FUNC_SKIP, 16'd32768);
      send(bfr_pkg::FUNC_TAIL, 0);
      send(bfr_pkg::FUNC_GET, 1);
      send(bfr_pkg::FUNC_START, 96);

      start <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);

      items_sent = 0;
      while (items_sent < RandItems) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               repeat ($urandom_range(1, 4)) begin
                  if (filled < bfr_pkg::BufBytes) begin
                     send(bfr_pkg::FUNC_WRITE, $urandom, $urandom, $urandom, $urandom,
                          filled, $urandom);
                     filled++;
                  end
               end
               if ($urandom_range(0, 1))
                  send(bfr_pkg::FUNC_WRITE, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
            end
            9: begin
               f = $urandom_range(bfr_pkg::FUNC_GET, FUNC_NOP);
               send(f, field_bits(), $urandom, $urandom, $urandom, $urandom, $urandom);
            end
            default: begin
               send(bfr_pkg::FUNC_START, $urandom_range(0, 8 * filled), $urandom,
                    $urandom, $urandom, $urandom, $urandom);
               ops = $urandom_range(3, 10);
               repeat (ops) begin
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3, 4: send(bfr_pkg::FUNC_GET, field_bits(), $urandom,
                                         $urandom, $urandom, $urandom, $urandom);
                     5: send(bfr_pkg::FUNC_SKIP, ($urandom_range(0, 5) == 0) ? $urandom
                                         : $urandom_range(0, 40), $urandom, $urandom,
                             $urandom, $urandom, $urandom);
                     6: send(bfr_pkg::FUNC_TAIL, ($urandom_range(0, 5) == 0) ? $urandom
                                         : $urandom_range(0, 200), $urandom, $urandom,
                             $urandom, $urandom, $urandom);
                     7: send(bfr_pkg::FUNC_SAVE, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
                     8: send(bfr_pkg::FUNC_RESTORE, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom);
                     default: send(FUNC_NOP, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom);
                  endcase
               end
            end
         endcase
      end

      start <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

FILE: bitstream_field_reader.f
+incdir+rtl
rtl/bfr_pkg.sv
rtl/bfr_ctrl.sv
rtl/bfr_datapath.sv
rtl/bitstream_field_reader.sv
bench/bitstream_field_reader_checker.sv
bench/testbench.sv
